>>> design/hpt_pkg.sv
// shared constants and types of the homogeneous point transform
package hpt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_W      = 32 + FRAC_BITS;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QW         = DIV_STAGES * DIV_STEP;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 3;

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  localparam logic [63:0] CFG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef enum logic [1:0] {
    CMD_PRE_3D  = 2'd0,
    CMD_POST_3D = 2'd1,
    CMD_PRE_4D  = 2'd2,
    CMD_POST_4D = 2'd3
  } cmd_e;

  typedef logic signed [31:0] entry_t;
  typedef entry_t [3:0] vec_t;
  typedef vec_t [3:0] matrix_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               divisor_was_zero;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic is3d;
    logic ovf;
  } side_t;

endpackage

>>> design/homogeneous_point_transform.sv
// top level of the homogeneous point transform
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o   in_item_i
//   out      out        out_valid_o / out_ready_i out_item_o
//
// one transaction per cycle on Q16.16 values; the path runs through three
// multiply-accumulate stages and the divide pipeline at 4 bits a stage
// the whole pipeline holds while the output register is full and not taken
// reset clears all valid bits and loads the matrix given by CFG_RESET
module homogeneous_point_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hpt_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hpt_pkg::out_item_t            out_item_o
);

  hpt_pkg::matrix_t matrix;
  hpt_pkg::vec_t    mac_r;
  hpt_pkg::side_t   mac_side;
  logic             mac_valid;
  logic             en;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  hpt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .matrix_o    (matrix)
  );

  hpt_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .item_i   (in_item_i),
    .matrix_i (matrix),
    .valid_o  (mac_valid),
    .r_o      (mac_r),
    .side_o   (mac_side)
  );

  hpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mac_valid),
    .r_i     (mac_r),
    .side_i  (mac_side),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

  a_zero_div_w_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.divisor_was_zero |-> out_item_o.out_w == hpt_pkg::ONE)
    else $error("zero divisor without unit w");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output free");

endmodule

>>> design/hpt_cfg_regs.sv
// matrix register file written through the configuration port
module hpt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [63:0]                     cfg_data_i,
  output hpt_pkg::matrix_t                matrix_o
);

  logic [63:0] pair_q [hpt_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
        pair_q[i] <= hpt_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid_i) begin
      pair_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        matrix_o[r][c] = pair_q[r*2 + c/2][(c%2)*32 +: 32];
      end
    end
  end

endmodule

>>> design/hpt_mac.sv
// three-stage multiply, saturate and accumulate of the four lanes
module hpt_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  hpt_pkg::in_item_t item_i,
  input  hpt_pkg::matrix_t  matrix_i,
  output logic              valid_o,
  output hpt_pkg::vec_t     r_o,
  output hpt_pkg::side_t    side_o
);

  logic signed [63:0] prod_d [4][4];
  logic signed [63:0] prod_q [4][4];
  logic signed [31:0] term_d [4][4];
  logic signed [31:0] term_q [4][4];
  logic               tovf_d;
  hpt_pkg::vec_t      r_d;
  hpt_pkg::vec_t      r_q;
  logic               sovf_d;
  hpt_pkg::side_t     side1_d;
  hpt_pkg::side_t     side1_q, side2_q, side3_q;
  logic [2:0]         vld_q;

  // stage 1: products
  always_comb begin
    hpt_pkg::vec_t v;
    logic          pre;
    logic signed [31:0] m;
    pre = (hpt_pkg::cmd_e'(item_i.command) == hpt_pkg::CMD_PRE_3D) ||
          (hpt_pkg::cmd_e'(item_i.command) == hpt_pkg::CMD_PRE_4D);
    side1_d.is3d = !item_i.command[1];
    side1_d.ovf  = 1'b0;
    v[0] = item_i.in_x;
    v[1] = item_i.in_y;
    v[2] = item_i.in_z;
    v[3] = side1_d.is3d ? hpt_pkg::ONE : item_i.in_w;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        m = pre ? matrix_i[i][k] : matrix_i[k][i];
        prod_d[k][i] = m * v[i];
      end
    end
  end

  // stage 2: floor shift and saturate each term
  always_comb begin
    logic signed [63:0] t;
    tovf_d = side1_q.ovf;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        t = prod_q[k][i] >>> hpt_pkg::FRAC_BITS;
        if (t > 64'sd2147483647) begin
          term_d[k][i] = 32'sh7fffffff;
          tovf_d = 1'b1;
        end else if (t < -64'sd2147483648) begin
          term_d[k][i] = 32'sh80000000;
          tovf_d = 1'b1;
        end else begin
          term_d[k][i] = t[31:0];
        end
      end
    end
  end

  // stage 3: exact sum, saturate once
  always_comb begin
    logic signed [33:0] s;
    sovf_d = side2_q.ovf;
    for (int k = 0; k < 4; k++) begin
      s = 34'(term_q[k][0]) + 34'(term_q[k][1]) + 34'(term_q[k][2]) + 34'(term_q[k][3]);
      if (s > 34'sd2147483647) begin
        r_d[k] = 32'sh7fffffff;
        sovf_d = 1'b1;
      end else if (s < -34'sd2147483648) begin
        r_d[k] = 32'sh80000000;
        sovf_d = 1'b1;
      end else begin
        r_d[k] = s[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      side1_q <= side1_d;
      term_q  <= term_d;
      side2_q <= '{is3d: side1_q.is3d, ovf: tovf_d};
      r_q     <= r_d;
      side3_q <= '{is3d: side2_q.is3d, ovf: sovf_d};
    end
  end

  assign valid_o = vld_q[2];
  assign r_o     = r_q;
  assign side_o  = side3_q;

endmodule

>>> design/hpt_div.sv
// pipelined perspective divide, DIV_STEP (4) quotient bits per stage
module hpt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  hpt_pkg::vec_t      r_i,
  input  hpt_pkg::side_t     side_i,
  output logic               valid_o,
  output hpt_pkg::out_item_t item_o
);

  localparam int NS = hpt_pkg::DIV_STAGES;

  logic [hpt_pkg::QW-1:0] n_q   [NS+1][3];
  logic [31:0]            rem_q [NS+1][3];
  logic [31:0]            dm_q  [NS+1];
  logic [2:0]             neg_q [NS+1];
  logic                   dz_q  [NS+1];
  hpt_pkg::side_t         side_q[NS+1];
  hpt_pkg::vec_t          r_q   [NS+1];
  logic [NS:0]            vld_q;

  logic [hpt_pkg::QW-1:0] n0_d [3];
  logic [31:0]            dm0_d;
  logic [2:0]             neg0_d;
  logic                   dz0_d;

  // setup: magnitudes and signs
  always_comb begin
    logic [31:0]                  dsel;
    logic signed [hpt_pkg::NUM_W-1:0] num;
    logic [hpt_pkg::NUM_W-1:0]    nmag;
    dz0_d = side_i.is3d && (r_i[3] == 32'sd0);
    dsel  = dz0_d ? hpt_pkg::ONE : r_i[3];
    dm0_d = dsel[31] ? (~dsel + 32'd1) : dsel;
    for (int k = 0; k < 3; k++) begin
      num       = {r_i[k], {hpt_pkg::FRAC_BITS{1'b0}}};
      nmag      = num[hpt_pkg::NUM_W-1] ? (~num + 1'b1) : num;
      n0_d[k]   = hpt_pkg::QW'(nmag);
      neg0_d[k] = r_i[k][31] ^ dsel[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        n_q[0][k]   <= n0_d[k];
        rem_q[0][k] <= '0;
      end
      dm_q[0]   <= dm0_d;
      neg_q[0]  <= neg0_d;
      dz_q[0]   <= dz0_d;
      side_q[0] <= side_i;
      r_q[0]    <= r_i;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    logic [hpt_pkg::QW-1:0] n_d   [3];
    logic [31:0]            rem_d [3];

    always_comb begin
      logic [32:0]            rt;
      logic [31:0]            rem;
      logic [hpt_pkg::QW-1:0] n;
      for (int k = 0; k < 3; k++) begin
        rem = rem_q[s-1][k];
        n   = n_q[s-1][k];
        for (int j = 0; j < hpt_pkg::DIV_STEP; j++) begin
          rt = {rem, n[hpt_pkg::QW-1]};
          n  = n << 1;
          if (rt >= {1'b0, dm_q[s-1]}) begin
            rem  = 32'(rt - {1'b0, dm_q[s-1]});
            n[0] = 1'b1;
          end else begin
            rem = rt[31:0];
          end
        end
        n_d[k]   = n;
        rem_d[k] = rem;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]    <= n_d;
        rem_q[s]  <= rem_d;
        dm_q[s]   <= dm_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        dz_q[s]   <= dz_q[s-1];
        side_q[s] <= side_q[s-1];
        r_q[s]    <= r_q[s-1];
      end
    end
  end

  // sign, saturation and 4D pass-through
  hpt_pkg::out_item_t item_d;
  hpt_pkg::out_item_t item_q;
  logic               vld_out_q;

  always_comb begin
    logic [hpt_pkg::QW-1:0] q;
    logic [31:0]            res [3];
    logic                   ovf;
    ovf = side_q[NS].ovf;
    for (int k = 0; k < 3; k++) begin
      q = n_q[NS][k];
      if (!side_q[NS].is3d) begin
        res[k] = r_q[NS][k];
      end else if (!neg_q[NS][k] && (|q[hpt_pkg::QW-1:31])) begin
        res[k] = 32'h7fffffff;
        ovf    = 1'b1;
      end else if (neg_q[NS][k] && ((|q[hpt_pkg::QW-1:32]) || (q[31] && (|q[30:0])))) begin
        res[k] = 32'h80000000;
        ovf    = 1'b1;
      end else begin
        res[k] = neg_q[NS][k] ? (~q[31:0] + 32'd1) : q[31:0];
      end
    end
    item_d.out_x            = res[0];
    item_d.out_y            = res[1];
    item_d.out_z            = res[2];
    item_d.out_w            = side_q[NS].is3d ? hpt_pkg::ONE : r_q[NS][3];
    item_d.divisor_was_zero = dz_q[NS];
    item_d.overflow         = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = vld_out_q;
  assign item_o  = item_q;

endmodule

>>> tb/testbench.sv
// testbench for the homogeneous point transform: random and directed points against a predictor
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  hpt_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hpt_pkg::out_item_t out_item;

  logic [63:0] matrix_regs [hpt_pkg::NUM_REGS];
  hpt_pkg::in_item_t point_queue [$];
  hpt_pkg::out_item_t expected_points [$];
  int error_count = 0;
  int hold_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit in_ready_seen = 1'b0;

  homogeneous_point_transform DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item)
  );

  always #2 clk = ~clk;

  function automatic longint sat_word(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint matrix_entry(int r, int c);
    logic [63:0] pair;
    pair = matrix_regs[r * 2 + (c >> 1)];
    return longint'(hpt_pkg::entry_t'((c & 1) ? pair[63:32] : pair[31:0]));
  endfunction

  function automatic hpt_pkg::out_item_t transform_point(hpt_pkg::in_item_t p);
    hpt_pkg::out_item_t res;
    bit pre, is3d, ovf, dz;
    longint v [4];
    longint r [4];
    longint acc, m, prod, d;
    pre = (p.command == hpt_pkg::CMD_PRE_3D) || (p.command == hpt_pkg::CMD_PRE_4D);
    is3d = (p.command == hpt_pkg::CMD_PRE_3D) || (p.command == hpt_pkg::CMD_POST_3D);
    ovf = 1'b0;
    dz = 1'b0;
    v[0] = longint'(p.in_x);
    v[1] = longint'(p.in_y);
    v[2] = longint'(p.in_z);
    v[3] = is3d ? longint'(hpt_pkg::ONE) : longint'(p.in_w);
    for (int k = 0; k < 4; k++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        m = pre ? matrix_entry(i, k) : matrix_entry(k, i);
        if (i == 3 && is3d) acc += m;
        else begin
          prod = (m * v[i]) >>> hpt_pkg::FRAC_BITS;
          acc += sat_word(prod, ovf);
        end
      end
      r[k] = sat_word(acc, ovf);
    end
    if (is3d) begin
      d = r[3];
      if (d == 0) begin
        d = longint'(hpt_pkg::ONE);
        dz = 1'b1;
      end
      for (int k = 0; k < 3; k++)
        r[k] = sat_word((r[k] * longint'(hpt_pkg::ONE)) / d, ovf);
      r[3] = longint'(hpt_pkg::ONE);
    end
    res.out_x = r[0][31:0];
    res.out_y = r[1][31:0];
    res.out_z = r[2][31:0];
    res.out_w = r[3][31:0];
    res.divisor_was_zero = dz;
    res.overflow = ovf;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      3: return 32'($signed($urandom_range(0, 1024)) - 512);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_entry();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return hpt_pkg::ONE;
      4: return $urandom;
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic hpt_pkg::in_item_t random_point();
    hpt_pkg::in_item_t p;
    p.command = 2'($urandom_range(0, 3));
    p.in_x = random_coord();
    p.in_y = random_coord();
    p.in_z = random_coord();
    p.in_w = random_coord();
    return p;
  endfunction

  function automatic void add_point(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z, logic [31:0] w);
    hpt_pkg::in_item_t p;
    p.command = cmd;
    p.in_x = x;
    p.in_y = y;
    p.in_z = z;
    p.in_w = w;
    point_queue.push_back(p);
  endfunction

  task automatic write_matrix_reg(int idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= hpt_pkg::CFG_IDX_W'(idx);
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    matrix_regs[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (point_queue.size() != 0 || expected_points.size() != 0 || in_valid) @(posedge clk);
    repeat (5 + hpt_pkg::DIV_STAGES + 5) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_ready_seen) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (point_queue.size() != 0) begin
        in_item <= point_queue.pop_front();
        in_valid <= 1'b1;
        send_gap <= ($urandom_range(0, 9) < 7) ? 0 :
                    (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_points.push_back(transform_point(in_item));
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) >= 7)
        recv_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  // monitor
  always @(posedge clk) begin
    hpt_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $display("unexpected transaction at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_item.out_x !== want.out_x) report_mismatch("out_x", out_item.out_x, want.out_x);
        if (out_item.out_y !== want.out_y) report_mismatch("out_y", out_item.out_y, want.out_y);
        if (out_item.out_z !== want.out_z) report_mismatch("out_z", out_item.out_z, want.out_z);
        if (out_item.out_w !== want.out_w) report_mismatch("out_w", out_item.out_w, want.out_w);
        if (out_item.divisor_was_zero !== want.divisor_was_zero)
          report_mismatch("divisor_was_zero", 32'(out_item.divisor_was_zero),
                          32'(want.divisor_was_zero));
        if (out_item.overflow !== want.overflow)
          report_mismatch("overflow", 32'(out_item.overflow), 32'(want.overflow));
      end
    end
  end

  initial begin
    for (int i = 0; i < hpt_pkg::NUM_REGS; i++) matrix_regs[i] = hpt_pkg::CFG_RESET[i];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset matrix: extremes of x, y and w, each command
    for (int c = 0; c < 4; c++) begin
      add_point(2'(c), 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'h7fff_ffff);
      add_point(2'(c), 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
      add_point(2'(c), hpt_pkg::ONE, 32'(-2 * 65536), 32'd3 << 16, 32'd0);
    end
    drain_pipeline();

    // perspective-like matrix: zero divisor and saturated divisor
    write_matrix_reg(6, 64'd0);
    write_matrix_reg(7, {32'd0, hpt_pkg::ONE});
    write_matrix_reg(1, {32'h7fff_ffff, 32'd0});
    add_point(hpt_pkg::CMD_PRE_3D, hpt_pkg::ONE, hpt_pkg::ONE, 32'd0, 32'd0);
    add_point(hpt_pkg::CMD_POST_3D, hpt_pkg::ONE, hpt_pkg::ONE, 32'd0, 32'd0);
    add_point(hpt_pkg::CMD_PRE_3D, hpt_pkg::ONE, hpt_pkg::ONE, 32'h7fff_ffff, 32'd0);
    add_point(hpt_pkg::CMD_POST_3D, 32'd5 << 16, hpt_pkg::ONE, 32'h8000_0000, 32'd0);
    add_point(hpt_pkg::CMD_PRE_3D, 32'd7 << 16, 32'd1, 32'd1, 32'd0);
    add_point(hpt_pkg::CMD_POST_4D, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff);
    drain_pipeline();

    // random or extreme matrices with random points, long output stall in the second phase
    for (int phase = 0; phase < 6; phase++) begin
      for (int r = 0; r < hpt_pkg::NUM_REGS; r++) begin
        if (phase == 5) write_matrix_reg(r, 64'hffff_ffff_ffff_ffff);
        else if (phase == 4) write_matrix_reg(r, {32'h7fff_ffff, 32'h8000_0000});
        else write_matrix_reg(r, {random_entry(), random_entry()});
      end
      if (phase == 1) hold_cycles = 300;
      for (int n = 0; n < 165; n++) point_queue.push_back(random_point());
      drain_pipeline();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
